// ===== rtl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared widths, sequencer step codes and the control-word program of the
// sorted table bracket search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Field widths of the stream payloads.
    localparam int IDX_W         = 11;
    localparam int ENTRY_IDX_W   = 10;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 11;
    localparam int S_TDATA_W     = 80;
    localparam int M_TDATA_W     = 24;
    localparam int TABLE_DEPTH_DEF = 1024;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sequencer step addresses.
    typedef enum logic [2:0] {
        ST_FETCH   = 3'd0,
        ST_EDGE_LO = 3'd1,
        ST_EDGE_HI = 3'd2,
        ST_SPLIT   = 3'd3,
        ST_PROBE   = 3'd4
    } step_t;

    // Which table address a step reads.
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_FIRST = 2'd1,
        RD_LAST  = 2'd2,
        RD_MID   = 2'd3
    } rd_sel_t;

    // Datapath action of a step.
    typedef enum logic [2:0] {
        ACT_ACCEPT  = 3'd0,
        ACT_EDGE_LO = 3'd1,
        ACT_EDGE_HI = 3'd2,
        ACT_SPLIT   = 3'd3,
        ACT_PROBE   = 3'd4
    } act_t;

    // One control word: the action, the read it issues, the step that
    // follows normally and the step taken when the exit condition holds.
    typedef struct packed {
        act_t    act;
        rd_sel_t rd_sel;
        step_t   next_step;
        step_t   exit_step;
    } ucode_t;

    // The control program. Every exit returns to the fetch step.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        unique case (step)
            ST_FETCH:   w = '{ACT_ACCEPT,  RD_FIRST, ST_EDGE_LO, ST_FETCH};
            ST_EDGE_LO: w = '{ACT_EDGE_LO, RD_LAST,  ST_EDGE_HI, ST_FETCH};
            ST_EDGE_HI: w = '{ACT_EDGE_HI, RD_NONE,  ST_SPLIT,   ST_FETCH};
            ST_SPLIT:   w = '{ACT_SPLIT,   RD_MID,   ST_PROBE,   ST_FETCH};
            ST_PROBE:   w = '{ACT_PROBE,   RD_NONE,  ST_SPLIT,   ST_FETCH};
            default:    w = '{ACT_ACCEPT,  RD_NONE,  ST_FETCH,   ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Simple dual-port RAM: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sorted_table_bracket_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_bracket_search_core
// Sorted table with bracket search, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// A load beat writes one table entry. For a query beat, three steps read
// and check the first and last entries, then each probe of the interval
// search costs two steps, one to issue the read of the midpoint on the
// single table read port and one to compare the registered read data with
// the key. The result sits in an output register, so the next beat is
// accepted while it waits to be taken. The table is not cleared; entries
// must be written before they are searched, and the table is expected to
// be sorted ascending.
module sorted_table_bracket_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: entry_count.
    input  logic                             cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]     cfg_wr_data,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: entry_index[9:0], entry_value[41:10], search_key[73:42], zeros.
    input  logic [stbs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: operation.
    input  logic                             s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: lower_index[10:0], upper_index[21:11], zeros.
    output logic [stbs_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: exact_match.
    output logic                             m_tuser
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int IW    = stbs_pkg::IDX_W;
    localparam int VW    = stbs_pkg::VALUE_W;
    localparam int EW    = stbs_pkg::ENTRY_IDX_W;
    localparam int PAD_W = stbs_pkg::M_TDATA_W - 2 * IW;
    // Largest count the 11-bit register can select within the table.
    localparam logic [IW-1:0] DEPTH_CAP =
        IW'((TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH);

    // Input fields.
    logic [EW-1:0]        in_entry_index;
    logic signed [VW-1:0] in_entry_value;
    logic signed [VW-1:0] in_search_key;

    assign in_entry_index = s_tdata[EW-1:0];
    assign in_entry_value = s_tdata[EW+VW-1:EW];
    assign in_search_key  = s_tdata[EW+2*VW-1:EW+VW];

    // Sequencer and control registers.
    stbs_pkg::step_t  pc_reg, pc_next;
    stbs_pkg::ucode_t uc;
    logic [IW-1:0]    cfg_reg;
    logic             out_valid_reg;

    // Datapath registers.
    logic signed [VW-1:0] key_reg;
    logic [IW-1:0]        l_reg;
    logic [IW-1:0]        r_reg;
    logic [IW-1:0]        m_reg;
    logic                 lo_gt_reg;
    logic                 lo_eq_reg;
    logic [IW-1:0]        out_lower_reg, out_lower_next;
    logic [IW-1:0]        out_upper_reg, out_upper_next;
    logic                 out_match_reg, out_match_next;

    // Decoded step signals.
    logic                 query_acc;
    logic                 emit;
    logic                 exit_cond;
    logic                 out_free;
    logic                 stall;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [VW-1:0]        ram_rdata;
    logic signed [VW-1:0] rd_val;
    logic [IW-1:0]        cnt_eff;
    logic [IW-1:0]        mid;

    assign uc       = stbs_pkg::ucode_rom(pc_reg);
    assign rd_val   = $signed(ram_rdata);
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = emit && !out_free;
    assign mid      = l_reg + ((r_reg - l_reg) >> 1);

    // Effective count: zero reads as one, large counts clip to the depth.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cnt_eff = IW'(1);
        end
        else if (cfg_reg > DEPTH_CAP)
        begin
            cnt_eff = DEPTH_CAP;
        end
        else
        begin
            cnt_eff = cfg_reg;
        end
    end

    // Step outputs: handshake, exit condition, table access and result.
    always_comb
    begin
        s_tready       = 1'b0;
        query_acc      = 1'b0;
        emit           = 1'b0;
        ram_we         = 1'b0;
        out_lower_next = l_reg;
        out_upper_next = r_reg;
        out_match_next = 1'b0;
        unique case (uc.act)
            stbs_pkg::ACT_ACCEPT:
            begin
                s_tready  = 1'b1;
                query_acc = s_tvalid && (s_tuser == stbs_pkg::OP_QUERY);
                ram_we    = s_tvalid && (s_tuser == stbs_pkg::OP_LOAD)
                            && (32'(in_entry_index) < 32'(TABLE_DEPTH));
            end
            stbs_pkg::ACT_EDGE_LO:
            begin
                emit = 1'b0;
            end
            stbs_pkg::ACT_EDGE_HI:
            begin
                emit = 1'b1;
                priority if (lo_gt_reg)
                begin
                    out_lower_next = '1;
                    out_upper_next = '0;
                end
                else if (rd_val < key_reg)
                begin
                    out_lower_next = r_reg;
                    out_upper_next = r_reg + IW'(1);
                end
                else if (lo_eq_reg)
                begin
                    out_lower_next = '0;
                    out_upper_next = '0;
                    out_match_next = 1'b1;
                end
                else if (rd_val == key_reg)
                begin
                    out_lower_next = r_reg;
                    out_upper_next = r_reg;
                    out_match_next = 1'b1;
                end
                else
                begin
                    emit = 1'b0;
                end
            end
            stbs_pkg::ACT_SPLIT:
            begin
                emit = (mid == l_reg) || (mid == r_reg);
            end
            stbs_pkg::ACT_PROBE:
            begin
                emit           = (rd_val == key_reg);
                out_lower_next = m_reg;
                out_upper_next = m_reg;
                out_match_next = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        exit_cond = (uc.act == stbs_pkg::ACT_ACCEPT) ? !query_acc : emit;
        ram_re    = (uc.rd_sel != stbs_pkg::RD_NONE) && !exit_cond;
        unique case (uc.rd_sel)
            stbs_pkg::RD_FIRST: ram_raddr = '0;
            stbs_pkg::RD_LAST:  ram_raddr = AW'(r_reg);
            stbs_pkg::RD_MID:   ram_raddr = AW'(mid);
            default:            ram_raddr = '0;
        endcase
    end

    // Next step.
    always_comb
    begin
        pc_next = pc_reg;
        if (!stall)
        begin
            pc_next = exit_cond ? uc.exit_step : uc.next_step;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= stbs_pkg::ST_FETCH;
            cfg_reg       <= IW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath registers.
    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            key_reg <= in_search_key;
            l_reg   <= '0;
            r_reg   <= cnt_eff - IW'(1);
        end
        if (uc.act == stbs_pkg::ACT_EDGE_LO)
        begin
            lo_gt_reg <= (rd_val > key_reg);
            lo_eq_reg <= (rd_val == key_reg);
        end
        if ((uc.act == stbs_pkg::ACT_SPLIT) && !emit)
        begin
            m_reg <= mid;
        end
        if ((uc.act == stbs_pkg::ACT_PROBE) && !emit)
        begin
            if (rd_val < key_reg)
            begin
                l_reg <= m_reg;
            end
            else
            begin
                r_reg <= m_reg;
            end
        end
        if (emit && out_free)
        begin
            out_lower_reg <= out_lower_next;
            out_upper_reg <= out_upper_next;
            out_match_reg <= out_match_next;
        end
    end

    // Table storage.
    stbs_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_entry_index)),
        .wdata (in_entry_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_upper_reg, out_lower_reg};
    assign m_tuser  = out_match_reg;

endmodule
